>>> design/bipartite_two_coloring_defines.svh
// Assertion macros for the bipartite two-coloring block.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef BIPARTITE_TWO_COLORING_DEFINES_SVH
`define BIPARTITE_TWO_COLORING_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define BPC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define BPC_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define BPC_ASSERT_ALWAYS(name, cond, msg)
`define BPC_ASSERT_IMPLY(name, ante, cons, msg)

`endif

`endif

>>> design/bpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bipartite two-coloring block.
// No dependencies; used by the interfaces, the top level and the testbench.
package bpc_pkg;

    // Field widths of the request, result and configuration register
    localparam int CMD_W    = 2;
    localparam int NODE_F_W = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;
    localparam int CFG_W    = 11;

    // Default store sizes
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 1024;

    // Node count after reset
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(1);

    // Node colours as held in the colour store
    localparam logic [1:0] COLOR_NONE = 2'd0;
    localparam logic [1:0] COLOR_ONE  = 2'd1;
    localparam logic [1:0] COLOR_TWO  = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EDGE_RD,
        ST_COLOR_RD,
        ST_UPDATE,
        ST_RD_COLOR,
        ST_RD_DONE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [NODE_F_W-1:0] node_a;
        logic [NODE_F_W-1:0] node_b;
        logic [INDEX_W-1:0]  edge_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                bipartite;
        logic                direction;
        logic [TOTAL_W-1:0]  edge_total;
    } rsp_t;

    // Opposite colour of a coloured node.
    function automatic logic [1:0] color_flip(input logic [1:0] c);
        return (c == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
    endfunction

endpackage

>>> design/bpc_req_if.sv
`timescale 1ns / 1ps
// Request channel of the bipartite two-coloring block.
// Depends on bpc_pkg for the request payload type.
interface bpc_req_if;
    logic          valid;
    logic          ready;
    bpc_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/bpc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the bipartite two-coloring block.
// Depends on bpc_pkg for the result payload type.
interface bpc_rsp_if;
    logic          valid;
    logic          ready;
    bpc_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/bipartite_two_coloring.sv
`timescale 1ns / 1ps
// Top level of the bipartite two-coloring block: edge store, colour store and sequencer.
// Depends on bpc_pkg, bpc_req_if, bpc_rsp_if and bipartite_two_coloring_defines.svh.
//
//   Channel   Kind          Contents
//   req       valid/ready   command, node_a, node_b, edge_index
//   rsp       valid/ready   status, bipartite, direction, edge_total
//   cfg       write only    node_count
//
// Clear, add and a read that fails or finds a non-bipartite graph are answered from the idle state.
// A read of a bipartite solve steps through edge read, colour read, direction and result.
// A solve clears the colours of all MAX_NODES nodes, then sweeps over the edges if there are any
// (changing sweeps, one quiet sweep, one checking sweep), then loads the result.
// Reset needs no clearing pass: every solve clears the colour store itself.
// A result not yet taken holds the request side not ready, as does a solve or read in progress.
`include "bipartite_two_coloring_defines.svh"

module bipartite_two_coloring #(
    parameter int MAX_NODES = bpc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = bpc_pkg::DEF_MAX_EDGES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bpc_pkg::CFG_W-1:0] cfg_wr_data,
    bpc_req_if.sink                   req,
    bpc_rsp_if.source                 rsp
);
    import bpc_pkg::*;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_DW = 2 * NODE_W;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

    // Stores
    logic [EDGE_DW-1:0] edge_mem [MAX_EDGES];
    logic [1:0]         color_mem [MAX_NODES];

    // Control registers
    state_t             state_reg, state_next;
    logic [ECNT_W-1:0]  edge_count_reg, edge_count_next;
    logic               solved_reg, solved_next;
    logic               bip_reg, bip_next;
    logic [ECNT_W-1:0]  k_reg, k_next;
    logic [NODE_W-1:0]  node_idx_reg, node_idx_next;
    logic               changed_reg, changed_next;
    logic               check_reg, check_next;
    logic               dir_reg, dir_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_data_reg, rsp_data_next;
    logic [CFG_W-1:0]   node_count_reg;

    // Memory ports
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    logic [EDGE_DW-1:0] edge_wdata;
    logic [EDGE_AW-1:0] edge_raddr;
    logic [EDGE_DW-1:0] edge_rdata_reg;
    logic               color_we;
    logic [NODE_W-1:0]  color_waddr;
    logic [1:0]         color_wdata;
    logic [1:0]         color_a_reg;
    logic [1:0]         color_b_reg;
    logic [NODE_W-1:0]  edge_a;
    logic [NODE_W-1:0]  edge_b;

    // Request checks
    logic [31:0]        node_lim;
    logic               a_ok;
    logic               b_ok;
    logic               store_full;
    logic               read_bad;
    logic               slot_free;
    logic               load_rsp;
    logic [STATUS_W-1:0] rsp_status;
    logic               rsp_dir;
    logic               step_changed;
    logic [ECNT_W-1:0]  k_inc;

    assign edge_a = edge_rdata_reg[EDGE_DW-1:NODE_W];
    assign edge_b = edge_rdata_reg[NODE_W-1:0];
    assign k_inc  = k_reg + ECNT_W'(1);

    // Node numbers are valid from one up to the smaller of node_count and MAX_NODES.
    assign node_lim   = (32'(node_count_reg) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                               : 32'(node_count_reg);
    assign a_ok       = (req.payload.node_a != '0) && (32'(req.payload.node_a) <= node_lim);
    assign b_ok       = (req.payload.node_b != '0) && (32'(req.payload.node_b) <= node_lim);
    assign store_full = 32'(edge_count_reg) >= 32'(MAX_EDGES);
    assign read_bad   = !solved_reg
                      || (32'(req.payload.edge_index) >= 32'(edge_count_reg));
    assign slot_free  = !rsp_valid_reg || rsp.ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // Edge store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata_reg <= edge_mem[edge_raddr];
    end

    // Colour store: one write port, two registered read ports at the ends of the edge read.
    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_waddr] <= color_wdata;
        end
        color_a_reg <= color_mem[edge_a];
        color_b_reg <= color_mem[edge_b];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_count_reg <= '0;
            solved_reg     <= 1'b0;
            bip_reg        <= 1'b0;
            k_reg          <= '0;
            node_idx_reg   <= '0;
            changed_reg    <= 1'b0;
            check_reg      <= 1'b0;
            dir_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            solved_reg     <= solved_next;
            bip_reg        <= bip_next;
            k_reg          <= k_next;
            node_idx_reg   <= node_idx_next;
            changed_reg    <= changed_next;
            check_reg      <= check_next;
            dir_reg        <= dir_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    // Sequencer: next state, store accesses and result loading
    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        solved_next     = solved_reg;
        bip_next        = bip_reg;
        k_next          = k_reg;
        node_idx_next   = node_idx_reg;
        changed_next    = changed_reg;
        check_next      = check_reg;
        dir_next        = dir_reg;
        edge_we         = 1'b0;
        edge_waddr      = EDGE_AW'(edge_count_reg);
        edge_wdata      = {NODE_W'(32'(req.payload.node_a) - 32'd1),
                           NODE_W'(32'(req.payload.node_b) - 32'd1)};
        edge_raddr      = EDGE_AW'(k_reg);
        color_we        = 1'b0;
        color_waddr     = node_idx_reg;
        color_wdata     = COLOR_NONE;
        req.ready       = 1'b0;
        load_rsp        = 1'b0;
        rsp_status      = STATUS_OK;
        rsp_dir         = 1'b0;
        step_changed    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready  = slot_free;
                edge_raddr = EDGE_AW'(req.payload.edge_index);
                if (req.valid && slot_free)
                begin
                    unique case (command_t'(req.payload.command))
                        CMD_CLEAR:
                        begin
                            edge_count_next = '0;
                            solved_next     = 1'b0;
                            bip_next        = 1'b0;
                            load_rsp        = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            load_rsp = 1'b1;
                            if (store_full || !a_ok || !b_ok)
                            begin
                                rsp_status = STATUS_RANGE;
                            end
                            else
                            begin
                                edge_we         = 1'b1;
                                edge_count_next = edge_count_reg + ECNT_W'(1);
                                solved_next     = 1'b0;
                                bip_next        = 1'b0;
                            end
                        end
                        CMD_SOLVE:
                        begin
                            node_idx_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            if (read_bad)
                            begin
                                rsp_status = STATUS_INDEX;
                                load_rsp   = 1'b1;
                            end
                            else if (!bip_reg)
                            begin
                                load_rsp = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RD_COLOR;
                            end
                        end
                    endcase
                end
            end

            // Clear every colour, node one gets colour one.
            ST_CLEAR:
            begin
                color_we    = 1'b1;
                color_wdata = (node_idx_reg == '0) ? COLOR_ONE : COLOR_NONE;
                if (node_idx_reg == LAST_NODE)
                begin
                    k_next       = '0;
                    changed_next = 1'b0;
                    check_next   = 1'b0;
                    if (edge_count_reg == '0)
                    begin
                        bip_next    = 1'b1;
                        solved_next = 1'b1;
                        dir_next    = 1'b0;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_EDGE_RD;
                    end
                end
                else
                begin
                    node_idx_next = node_idx_reg + NODE_W'(1);
                end
            end

            ST_EDGE_RD:
            begin
                state_next = ST_COLOR_RD;
            end

            ST_COLOR_RD:
            begin
                state_next = ST_UPDATE;
            end

            // One edge per visit: propagate a colour, or check for a conflict.
            ST_UPDATE:
            begin
                edge_raddr = EDGE_AW'(k_inc);
                if (!check_reg)
                begin
                    if (color_a_reg != COLOR_NONE && color_b_reg == COLOR_NONE)
                    begin
                        color_we     = 1'b1;
                        color_waddr  = edge_b;
                        color_wdata  = color_flip(color_a_reg);
                        step_changed = 1'b1;
                    end
                    else if (color_b_reg != COLOR_NONE && color_a_reg == COLOR_NONE)
                    begin
                        color_we     = 1'b1;
                        color_waddr  = edge_a;
                        color_wdata  = color_flip(color_b_reg);
                        step_changed = 1'b1;
                    end
                end
                else if (color_a_reg != COLOR_NONE && color_a_reg == color_b_reg)
                begin
                    bip_next = 1'b0;
                end

                if (k_inc == edge_count_reg)
                begin
                    k_next       = '0;
                    changed_next = 1'b0;
                    if (!check_reg)
                    begin
                        // Another sweep while colours still spread, else the checking sweep.
                        if (!(changed_reg || step_changed))
                        begin
                            check_next = 1'b1;
                            bip_next   = 1'b1;
                        end
                        state_next = ST_EDGE_RD;
                    end
                    else
                    begin
                        solved_next = 1'b1;
                        dir_next    = 1'b0;
                        state_next  = ST_RESULT;
                    end
                end
                else
                begin
                    k_next       = k_inc;
                    changed_next = changed_reg || step_changed;
                    state_next   = ST_COLOR_RD;
                end
            end

            ST_RD_COLOR:
            begin
                state_next = ST_RD_DONE;
            end

            ST_RD_DONE:
            begin
                dir_next   = (color_a_reg == COLOR_ONE);
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (slot_free)
                begin
                    load_rsp   = 1'b1;
                    rsp_dir    = dir_reg;
                    state_next = ST_IDLE;
                end
            end
        endcase

        // Result register: load a new result, or drop one that has been taken.
        rsp_data_next = rsp_data_reg;
        if (load_rsp)
        begin
            rsp_data_next.status     = rsp_status;
            rsp_data_next.bipartite  = bip_next;
            rsp_data_next.direction  = rsp_dir;
            rsp_data_next.edge_total = TOTAL_W'(32'(edge_count_next));
            rsp_valid_next           = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // Checks
    `BPC_ASSERT_ALWAYS(a_count_bound, 32'(edge_count_reg) <= 32'(MAX_EDGES), "count overflow")
    `BPC_ASSERT_IMPLY(a_result_solved, state_reg == ST_RESULT, solved_reg, "unsolved result")
    `BPC_ASSERT_IMPLY(a_idle_bip, state_reg == ST_IDLE, !bip_reg || solved_reg, "flag unsolved")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bipartite two-colouring block: a queue-fed driver,
// a checking monitor and an in-bench colouring predictor. Depends on bpc_pkg,
// bpc_req_if, bpc_rsp_if and bipartite_two_coloring.
module tb_top;
    import bpc_pkg::*;

    localparam int NODES = DEF_MAX_NODES;
    localparam int LINKS = DEF_MAX_EDGES;
    localparam int RANDOM_PER_PHASE = 200;

    typedef struct {
        req_t payload;
        bit   drain_first;
    } queued_request_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b1;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    bpc_req_if req_ch ();
    bpc_rsp_if rsp_ch ();

    // Requests waiting to be offered and results waiting to arrive
    queued_request_t request_q[$];
    rsp_t            expected_result_q[$];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_items = 0;
    int unsigned episodes = 0;
    int unsigned mismatches = 0;

    // Predictor state: the graph as loaded, the colours of the last solve and the node count
    logic [9:0]       link_from [LINKS];
    logic [9:0]       link_to   [LINKS];
    logic [1:0]       node_colour [NODES];
    int unsigned      links_held = 0;
    bit               solved_now = 1'b0;
    bit               bipartite_now = 1'b0;
    logic [CFG_W-1:0] nodes_cfg = NODE_COUNT_RST;

    bipartite_two_coloring DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Free-running clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit node_in_range(logic [NODE_F_W-1:0] v);
        int unsigned lim;
        lim = (nodes_cfg > NODES) ? NODES : nodes_cfg;
        return (v >= 1) && (v <= lim);
    endfunction

    function automatic logic [1:0] other_colour(logic [1:0] c);
        return (c == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
    endfunction

    // Colour the component of node one by repeated sweeps, then look for a clashing link.
    function automatic void colour_graph();
        bit changed;
        int unsigned k;
        changed = 1'b1;
        foreach (node_colour[n])
            node_colour[n] = COLOR_NONE;
        node_colour[0] = COLOR_ONE;
        while (changed)
        begin
            changed = 1'b0;
            for (k = 0; k < links_held; k++)
            begin
                if (node_colour[link_from[k]] != COLOR_NONE
                    && node_colour[link_to[k]] == COLOR_NONE)
                begin
                    node_colour[link_to[k]] = other_colour(node_colour[link_from[k]]);
                    changed = 1'b1;
                end
                else if (node_colour[link_to[k]] != COLOR_NONE
                         && node_colour[link_from[k]] == COLOR_NONE)
                begin
                    node_colour[link_from[k]] = other_colour(node_colour[link_to[k]]);
                    changed = 1'b1;
                end
            end
        end
        bipartite_now = 1'b1;
        for (k = 0; k < links_held; k++)
        begin
            if (node_colour[link_from[k]] != COLOR_NONE
                && node_colour[link_from[k]] == node_colour[link_to[k]])
                bipartite_now = 1'b0;
        end
        solved_now = 1'b1;
    endfunction

    // Apply one accepted request to the predictor state and return the result it owes.
    function automatic rsp_t predict_result(req_t r);
        rsp_t res;
        res = '0;
        res.status = STATUS_OK;
        case (command_t'(r.command))
            CMD_CLEAR:
            begin
                links_held = 0;
                solved_now = 1'b0;
                bipartite_now = 1'b0;
            end
            CMD_ADD:
            begin
                if (links_held >= LINKS || !node_in_range(r.node_a)
                    || !node_in_range(r.node_b))
                    res.status = STATUS_RANGE;
                else
                begin
                    link_from[links_held] = 10'(r.node_a - 1);
                    link_to[links_held] = 10'(r.node_b - 1);
                    links_held++;
                    solved_now = 1'b0;
                    bipartite_now = 1'b0;
                end
            end
            CMD_SOLVE:
                colour_graph();
            default:
            begin
                if (!solved_now || r.edge_index >= links_held)
                    res.status = STATUS_INDEX;
                else if (bipartite_now)
                    res.direction = (node_colour[link_from[r.edge_index]] == COLOR_ONE);
            end
        endcase
        res.bipartite = bipartite_now;
        res.edge_total = TOTAL_W'(links_held);
        return res;
    endfunction

    // Request driver: predicts on every accepted request, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        queued_request_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.payload <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_result_q.insert(expected_result_q.size(),
                                         predict_result(req_ch.payload));
            if (req_ch.valid && !req_ch.ready)
                req_ch.valid <= 1'b1;
            else if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct
                     && !(request_q[0].drain_first && expected_result_q.size() != 0))
            begin
                nxt = request_q.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.payload <= nxt.payload;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    task automatic note_mismatch(string what, rsp_t want, rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected status=%0d bip=%0d dir=%0d total=%0d, got status=%0d bip=%0d dir=%0d total=%0d",
                     $time, what, want.status, want.bipartite, want.direction, want.edge_total,
                     got.status, got.bipartite, got.direction, got.edge_total);
    endtask

    // Result monitor: checks each accepted result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rsp_t want;
        rsp_t got;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.payload;
                if (expected_result_q.size() == 0)
                    note_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_result_q.pop_front();
                    if (got.status !== want.status || got.bipartite !== want.bipartite
                        || got.direction !== want.direction
                        || got.edge_total !== want.edge_total)
                        note_mismatch("result mismatch", want, got);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_request(command_t cmd, int unsigned a, int unsigned b,
                                 int unsigned idx, bit hold = 1'b0);
        queued_request_t q;
        q.payload.command = cmd;
        q.payload.node_a = NODE_F_W'(a);
        q.payload.node_b = NODE_F_W'(b);
        q.payload.edge_index = INDEX_W'(idx);
        q.drain_first = hold;
        request_q.insert(request_q.size(), q);
        phase_items++;
    endtask

    function automatic int unsigned any_node();
        return $urandom_range(0, 2047);
    endfunction

    function automatic int unsigned any_index();
        return $urandom_range(0, 1023);
    endfunction

    // Sampled on the falling edge, once every update of the rising edge has settled.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || req_ch.valid || expected_result_q.size() != 0);
    endtask

    task automatic configure_nodes(logic [CFG_W-1:0] value);
        wait_until_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        nodes_cfg = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // One graph: clear, load links (some out of range) in a random window of nodes,
    // solve and read, maybe then add a link that spoils it, read, solve and read.
    task automatic queue_episode(bit hold);
        int unsigned lim;
        int unsigned span;
        int unsigned base;
        int unsigned links;
        int unsigned a;
        int unsigned b;
        int unsigned k;
        lim = (nodes_cfg > NODES) ? NODES : nodes_cfg;
        span = (lim < 12) ? lim : $urandom_range(2, 12);
        base = (lim > span) ? $urandom_range(0, lim - span) : 0;
        links = $urandom_range(1, 12);
        queue_request(CMD_CLEAR, any_node(), any_node(), any_index(), hold);
        for (k = 0; k < links; k++)
        begin
            a = (k == 0) ? 1 : base + $urandom_range(1, span);
            b = base + $urandom_range(1, span);
            if ($urandom_range(9) == 0)
                b = $urandom_range(1) ? 0 : $urandom_range(lim + 1, 2047);
            queue_request(CMD_ADD, a, b, any_index());
        end
        queue_request(CMD_SOLVE, any_node(), any_node(), any_index());
        repeat ($urandom_range(1, 5))
            queue_request(CMD_READ, any_node(), any_node(), $urandom_range(0, links + 1));
        if ($urandom_range(3) == 0)
        begin
            queue_request(CMD_ADD, base + $urandom_range(1, span),
                          base + $urandom_range(1, span), any_index());
            queue_request(CMD_READ, any_node(), any_node(), $urandom_range(0, links));
            queue_request(CMD_SOLVE, any_node(), any_node(), any_index());
            queue_request(CMD_READ, any_node(), any_node(), $urandom_range(0, links + 1));
        end
    endtask

    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                    logic [CFG_W-1:0] count);
        configure_nodes(count);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items = 0;
        while (phase_items < RANDOM_PER_PHASE)
        begin
            if ($urandom_range(4) == 0)
                queue_request(command_t'($urandom_range(3)), any_node(), any_node(),
                              any_index());
            else
            begin
                queue_episode(episodes % 6 == 3);
                episodes++;
            end
        end
    endtask

    // Main sequence: reset, directed cases, then the random phases.
    initial
    begin : stimulus
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Single node after reset: read before solve, empty solve, self-loop on node one
        queue_request(CMD_READ, 1, 1, 0);
        queue_request(CMD_SOLVE, 0, 0, 0);
        queue_request(CMD_READ, 1, 1, 0);
        queue_request(CMD_ADD, 1, 2, 0);
        queue_request(CMD_ADD, 1, 1, 0);
        queue_request(CMD_SOLVE, 0, 0, 0);
        queue_request(CMD_READ, 0, 0, 0);
        configure_nodes(CFG_W'(1024));

        // Out-of-range ends, a second component, spoiled and non-bipartite solves
        queue_request(CMD_ADD, 0, 5, 0);
        queue_request(CMD_ADD, 1025, 3, 0);
        queue_request(CMD_ADD, 2047, 2047, 1023);
        queue_request(CMD_CLEAR, 2047, 2047, 1023);
        queue_request(CMD_ADD, 1, 1024, 0);
        queue_request(CMD_ADD, 700, 1024, 0);
        queue_request(CMD_ADD, 5, 6, 0);
        queue_request(CMD_READ, 0, 0, 0);
        queue_request(CMD_SOLVE, 0, 0, 0);
        queue_request(CMD_READ, 0, 0, 0);
        queue_request(CMD_READ, 0, 0, 1);
        queue_request(CMD_READ, 0, 0, 2);
        queue_request(CMD_READ, 0, 0, 3);
        queue_request(CMD_READ, 0, 0, 1023);
        queue_request(CMD_ADD, 1, 700, 0);
        queue_request(CMD_READ, 0, 0, 0);
        queue_request(CMD_SOLVE, 0, 0, 0);
        queue_request(CMD_READ, 0, 0, 0);

        run_random_phase(0, 0, CFG_W'(6));
        run_random_phase(66, 0, CFG_W'(300));
        run_random_phase(0, 66, CFG_W'(2));
        run_random_phase(12, 12, CFG_W'(2047));

        wait_until_drained();
        repeat (20) @(posedge clk);
        if (expected_result_q.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_result_q.size());
            mismatches += expected_result_q.size();
        end
        if (mismatches == 0)
            $display("** bipartite_two_coloring: PASSED **");
        else
            $display("** bipartite_two_coloring: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake
    initial
    begin : watchdog
        #40_000_000;
        $display("timeout with %0d results outstanding", expected_result_q.size());
        $display("** bipartite_two_coloring: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bpc_pkg.sv
design/bpc_req_if.sv
design/bpc_rsp_if.sv
design/bipartite_two_coloring.sv
test/tb_top.sv
